[hw/rtl/bcq_pkg.sv]
package bcq_pkg;

  // Scan modes of the front end
  localparam logic [2:0] MODE_CODE   = 3'd0;
  localparam logic [2:0] MODE_SLASH  = 3'd1;
  localparam logic [2:0] MODE_LINE   = 3'd2;
  localparam logic [2:0] MODE_BLOCK  = 3'd3;
  localparam logic [2:0] MODE_STAR   = 3'd4;
  localparam logic [2:0] MODE_STRING = 3'd5;

  // Operations handed from front to back
  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_PUSH  = 2'd1;
  localparam logic [1:0] OP_CLOSE = 2'd2;
  localparam logic [1:0] OP_QUOTE = 2'd3;

  // Closer codes
  localparam logic [1:0] CL_NONE    = 2'd0;
  localparam logic [1:0] CL_PAREN   = 2'd1;
  localparam logic [1:0] CL_BRACE   = 2'd2;
  localparam logic [1:0] CL_BRACKET = 2'd3;

  // Error kinds (bad closers are closer code minus one)
  localparam logic [2:0] ERR_QUOTE    = 3'd3;
  localparam logic [2:0] ERR_OVERFLOW = 3'd4;

  // Characters of interest
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_RBRACK  = 8'h5D;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;

  localparam logic [15:0] LINE_FIRST = 16'd1;
  localparam logic [15:0] LINE_MAX   = 16'hFFFF;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  typedef struct packed {
    logic [1:0]  op;
    logic [1:0]  closer;
    logic [15:0] line;
    logic        last;
  } op_t;

endpackage

[hw/rtl/bcq_front.sv]
module bcq_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_char,
  input  logic          in_last,
  input  logic          q_ready,
  output logic          q_valid,
  output bcq_pkg::op_t  q_op
);
  import bcq_pkg::*;

  logic [2:0]  mode;
  logic [2:0]  mode_next;
  logic [15:0] line;
  logic        bump;
  logic        code_path;
  logic [1:0]  op_kind;
  logic [1:0]  op_closer;
  logic        accept;

  always_comb begin
    mode_next = mode;
    bump      = 1'b0;
    code_path = 1'b0;
    op_kind   = OP_NONE;
    op_closer = CL_NONE;
    unique case (mode)
      MODE_SLASH: begin
        if (in_char == CH_SLASH) begin
          mode_next = MODE_LINE;
        end else if (in_char == CH_STAR) begin
          mode_next = MODE_BLOCK;
        end else begin
          code_path = 1'b1;
        end
      end
      MODE_LINE: begin
        if (in_char == CH_NEWLINE) begin
          bump      = 1'b1;
          mode_next = MODE_CODE;
        end
      end
      MODE_BLOCK: begin
        if (in_char == CH_STAR) begin
          mode_next = MODE_STAR;
        end else if (in_char == CH_NEWLINE) begin
          bump = 1'b1;
        end
      end
      MODE_STAR: begin
        if (in_char == CH_SLASH) begin
          mode_next = MODE_CODE;
        end else if (in_char != CH_STAR) begin
          mode_next = MODE_BLOCK;
          bump      = (in_char == CH_NEWLINE);
        end
      end
      MODE_STRING: begin
        if (in_char == CH_DQUOTE) begin
          mode_next = MODE_CODE;
        end else if (in_char == CH_NEWLINE) begin
          op_kind   = OP_QUOTE;
          bump      = 1'b1;
          mode_next = MODE_CODE;
        end
      end
      default: begin
        code_path = 1'b1;
      end
    endcase

    // Plain code byte, also the byte after a slash that opened nothing
    if (code_path) begin
      mode_next = MODE_CODE;
      unique case (in_char)
        CH_NEWLINE: bump      = 1'b1;
        CH_SLASH:   mode_next = MODE_SLASH;
        CH_DQUOTE:  mode_next = MODE_STRING;
        CH_LPAREN:  begin op_kind = OP_PUSH;  op_closer = CL_PAREN;   end
        CH_LBRACE:  begin op_kind = OP_PUSH;  op_closer = CL_BRACE;   end
        CH_LBRACK:  begin op_kind = OP_PUSH;  op_closer = CL_BRACKET; end
        CH_RPAREN:  begin op_kind = OP_CLOSE; op_closer = CL_PAREN;   end
        CH_RBRACE:  begin op_kind = OP_CLOSE; op_closer = CL_BRACE;   end
        CH_RBRACK:  begin op_kind = OP_CLOSE; op_closer = CL_BRACKET; end
        default: ;
      endcase
    end
  end

  assign in_ready = q_ready;
  assign accept   = in_valid && in_ready;

  // Only bytes that touch the stack, report, or end the text go to the back
  assign q_valid     = accept && ((op_kind != OP_NONE) || in_last);
  assign q_op.op     = op_kind;
  assign q_op.closer = op_closer;
  assign q_op.line   = line;
  assign q_op.last   = in_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_CODE;
      line <= LINE_FIRST;
    end else if (accept) begin
      if (in_last) begin
        mode <= MODE_CODE;
        line <= LINE_FIRST;
      end else begin
        mode <= mode_next;
        if (bump && (line != LINE_MAX)) begin
          line <= line + 16'd1;
        end
      end
    end
  end

endmodule

[hw/rtl/bcq_queue.sv]
module bcq_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  bcq_pkg::op_t  wr_op,
  output logic          rd_valid,
  input  logic          rd_ready,
  output bcq_pkg::op_t  rd_op
);
  import bcq_pkg::*;

  op_t                 slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   fill;
  logic                do_wr;
  logic                do_rd;

  assign wr_ready = (fill != (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign rd_valid = (fill != '0);
  assign rd_op    = slots[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        fill <= fill + 1'b1;
      end else if (do_rd && !do_wr) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

[hw/rtl/bcq_back.sv]
module bcq_back #(
  parameter int STACK_DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          op_valid,
  output logic          op_ready,
  input  bcq_pkg::op_t  op,
  output logic          res_valid,
  input  logic          res_ready,
  output logic [2:0]    res_kind,
  output logic [15:0]   res_line,
  output logic [1:0]    res_closer
);
  import bcq_pkg::*;

  localparam int CW        = $clog2(STACK_DEPTH + 1);
  localparam int MEM_DEPTH = (STACK_DEPTH > 2) ? STACK_DEPTH - 2 : 1;
  localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  // Top two entries live in registers, the rest in memory
  logic [1:0]        mem [MEM_DEPTH];
  logic [1:0]        top_r;
  logic [1:0]        second_r;
  logic [1:0]        rd_data;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic [CW-1:0]     wr_idx;
  logic [CW-1:0]     rd_idx;
  logic [1:0]        top;
  logic              fire;
  logic              do_push;
  logic              do_pop;
  logic              emit;
  logic [2:0]        kind;

  assign op_ready = !res_valid || res_ready;
  assign fire     = op_valid && op_ready;
  assign top      = (count == '0) ? CL_NONE : top_r;

  always_comb begin
    do_push = 1'b0;
    do_pop  = 1'b0;
    emit    = 1'b0;
    kind    = ERR_QUOTE;
    if (fire) begin
      unique case (op.op)
        OP_PUSH: begin
          if (count == CW'(STACK_DEPTH)) begin
            emit = 1'b1;
            kind = ERR_OVERFLOW;
          end else begin
            do_push = 1'b1;
          end
        end
        OP_CLOSE: begin
          if (top != op.closer) begin
            emit = 1'b1;
            kind = {1'b0, op.closer - 2'd1};
          end
          do_pop = (count != '0);
        end
        OP_QUOTE: begin
          emit = 1'b1;
          kind = ERR_QUOTE;
        end
        default: ;
      endcase
    end

    count_next = count;
    if (do_push) begin
      count_next = count + 1'b1;
    end else if (do_pop) begin
      count_next = count - 1'b1;
    end
    if (fire && op.last) begin
      count_next = '0;
    end
  end

  assign wr_idx = count - CW'(2);
  assign rd_idx = count_next - CW'(3);

  // Memory: spill the second entry on push, prefetch the entry below it
  always_ff @(posedge clk) begin
    if (do_push && (count >= CW'(2))) begin
      mem[wr_idx[MEM_AW-1:0]] <= second_r;
    end
    if (do_push && (count >= CW'(2))) begin
      rd_data <= second_r;
    end else begin
      rd_data <= mem[rd_idx[MEM_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      top_r    <= op.closer;
      second_r <= top_r;
    end else if (do_pop) begin
      top_r    <= second_r;
      second_r <= rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (op_ready) begin
      res_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (op_ready && emit) begin
      res_kind   <= kind;
      res_line   <= op.line;
      res_closer <= top;
    end
  end

endmodule

[hw/rtl/bracket_comment_quote_checker.sv]
// Bracket, comment and quote checker for C source text. Feed one source byte
// per beat on the s_ side, with s_tlast on the final byte of a text; after
// that byte all scan state returns to reset (line 1, code mode, empty bracket
// stack). Each error comes out as one beat on the m_ side: bad closer, a
// newline inside a string (reported with the line of the opening quote), or
// a bracket pushed onto a full stack of STACK_DEPTH entries. Line numbers
// saturate at 65535; escaped quotes are not recognized. Throughput is one
// byte per cycle while neither side stalls: the front end (mode tracker and
// line counter) classifies each byte, a four-entry queue carries stack
// operations to the back end, and the back end updates the bracket stack
// once per cycle unless its error beat is stalled (top two entries in
// registers, the rest in a memory with one write and one prefetched read).
// Either side stalls independently; m_tready low fills the queue and then
// drops s_tready. No clearing pass is needed after reset.
module bracket_comment_quote_checker #(
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_code
  input  logic        s_tlast,   // end_of_text
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // [2:0] error_kind, [18:3] line_number,
                                 // [20:19] expected_closer, [23:21] zero
);
  import bcq_pkg::*;

  op_t        fq_op;
  op_t        qb_op;
  logic       fq_valid;
  logic       fq_ready;
  logic       qb_valid;
  logic       qb_ready;
  logic [2:0]  err_kind;
  logic [15:0] err_line;
  logic [1:0]  err_closer;

  // Front: track scan mode and line, classify each byte
  bcq_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_char  (s_tdata),
    .in_last  (s_tlast),
    .q_ready  (fq_ready),
    .q_valid  (fq_valid),
    .q_op     (fq_op)
  );

  // Queue: decouple the two halves
  bcq_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_op    (fq_op),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_op    (qb_op)
  );

  // Back: apply stack operations, register error beats
  bcq_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .op_valid   (qb_valid),
    .op_ready   (qb_ready),
    .op         (qb_op),
    .res_valid  (m_tvalid),
    .res_ready  (m_tready),
    .res_kind   (err_kind),
    .res_line   (err_line),
    .res_closer (err_closer)
  );

  // Pack the error beat, kind in the low bits
  assign m_tdata = {3'b000, err_closer, err_line, err_kind};

endmodule

[verif/syntax_error_monitor.sv]
module syntax_error_monitor #(
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,
  output int          errors_waiting,
  output int          mismatches
);
  import bcq_pkg::*;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] line_no;
    logic [1:0]  closer;
  } syntax_error_t;

  syntax_error_t expected_errors[$];

  logic [2:0]  scan_mode;
  logic [1:0]  closers [STACK_DEPTH];
  int          depth;
  logic [15:0] line_no;
  int          fail_total = 0;

  task automatic restart_scan();
    scan_mode = MODE_CODE;
    depth     = 0;
    line_no   = LINE_FIRST;
  endtask

  function automatic logic [1:0] top_closer();
    return (depth == 0) ? CL_NONE : closers[depth-1];
  endfunction

  task automatic bump_line();
    if (line_no != LINE_MAX) line_no++;
  endtask

  task automatic flag(input logic [2:0] kind);
    expected_errors.push_back('{kind, line_no, top_closer()});
  endtask

  task automatic push_closer(input logic [1:0] code);
    if (depth >= STACK_DEPTH) begin
      flag(ERR_OVERFLOW);
    end else begin
      closers[depth] = code;
      depth++;
    end
  endtask

  // Bad closer kinds are the closer code minus one; pop even on a mismatch.
  task automatic pop_closer(input logic [1:0] code);
    if (top_closer() != code) flag({1'b0, code} - 3'd1);
    if (depth > 0) depth--;
  endtask

  task automatic code_byte(input logic [7:0] ch);
    case (ch)
      CH_NEWLINE: bump_line();
      CH_SLASH:   scan_mode = MODE_SLASH;
      CH_DQUOTE:  scan_mode = MODE_STRING;
      CH_LPAREN:  push_closer(CL_PAREN);
      CH_LBRACE:  push_closer(CL_BRACE);
      CH_LBRACK:  push_closer(CL_BRACKET);
      CH_RPAREN:  pop_closer(CL_PAREN);
      CH_RBRACE:  pop_closer(CL_BRACE);
      CH_RBRACK:  pop_closer(CL_BRACKET);
      default: ;
    endcase
  endtask

  task automatic scan_byte(input logic [7:0] ch, input logic last);
    case (scan_mode)
      MODE_SLASH: begin
        if (ch == CH_SLASH) scan_mode = MODE_LINE;
        else if (ch == CH_STAR) scan_mode = MODE_BLOCK;
        else begin
          scan_mode = MODE_CODE;
          code_byte(ch);
        end
      end
      MODE_LINE: begin
        if (ch == CH_NEWLINE) begin
          bump_line();
          scan_mode = MODE_CODE;
        end
      end
      MODE_BLOCK: begin
        if (ch == CH_STAR) scan_mode = MODE_STAR;
        else if (ch == CH_NEWLINE) bump_line();
      end
      MODE_STAR: begin
        if (ch == CH_SLASH) scan_mode = MODE_CODE;
        else if (ch != CH_STAR) begin
          scan_mode = MODE_BLOCK;
          if (ch == CH_NEWLINE) bump_line();
        end
      end
      MODE_STRING: begin
        if (ch == CH_DQUOTE) scan_mode = MODE_CODE;
        else if (ch == CH_NEWLINE) begin
          flag(ERR_QUOTE);
          bump_line();
          scan_mode = MODE_CODE;
        end
      end
      default: begin
        scan_mode = MODE_CODE;
        code_byte(ch);
      end
    endcase
    if (last) restart_scan();
  endtask

  task automatic report(input string field, input syntax_error_t got,
                        input syntax_error_t want);
    if (fail_total < 40)
      $display("%0t mismatch on %s: got kind %0d line %0d closer %0d,",
               $time, field, got.kind, got.line_no, got.closer,
               " want kind %0d line %0d closer %0d",
               want.kind, want.line_no, want.closer);
    fail_total++;
  endtask

  always @(posedge clk) begin : watch
    syntax_error_t got;
    syntax_error_t want;
    if (rst) begin
      restart_scan();
    end else begin
      if (s_tvalid && s_tready) scan_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        got = '{m_tdata[2:0], m_tdata[18:3], m_tdata[20:19]};
        if (expected_errors.size() == 0) begin
          report("unexpected error beat", got, got);
        end else begin
          want = expected_errors.pop_front();
          if (got.kind != want.kind) report("error_kind", got, want);
          if (got.line_no != want.line_no) report("line_number", got, want);
          if (got.closer != want.closer) report("expected_closer", got, want);
        end
      end
    end
    errors_waiting <= expected_errors.size();
    mismatches     <= fail_total;
  end

endmodule

[verif/testbench.sv]
module testbench;
  import bcq_pkg::*;

  localparam int DEPTH = 16;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] char_code
  logic        s_tlast = 1'b0;    // end_of_text
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;           // [2:0] error_kind, [18:3] line_number,
                                  // [20:19] expected_closer, [23:21] zero

  int errors_waiting;
  int mismatches;
  int send_idle = 33;             // percent of cycles the byte source holds off
  int recv_idle = 61;             // percent of cycles the error sink stalls
  int bytes_sent = 0;

  logic [7:0] text_q[$];          // source text being assembled for one run

  always #2 clk = ~clk;

  bracket_comment_quote_checker #(.STACK_DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  syntax_error_monitor #(.STACK_DEPTH(DEPTH)) syntax_watch (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tlast        (s_tlast),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .errors_waiting (errors_waiting),
    .mismatches     (mismatches)
  );

  // Stall the error sink at random; one decision per cycle, made at the
  // falling edge so the rising edge always sees a settled value.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle);
  end

  // Hard stop in case the block hangs on either handshake.
  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

  // Filler for comment and string bodies: letters, space, semicolon, quote, star,
  // slash, newline and the brackets ( ) [ }, so comments and strings hide real tokens.
  function automatic logic [7:0] body_char(input int idx);
    case (idx)
      0:       return 8'h61;
      1:       return 8'h7A;
      2:       return 8'h20;
      3:       return 8'h3B;
      4:       return CH_DQUOTE;
      5:       return CH_LPAREN;
      6:       return CH_RBRACE;
      7:       return CH_LBRACK;
      8:       return CH_RPAREN;
      9:       return CH_STAR;
      10:      return CH_SLASH;
      default: return CH_NEWLINE;
    endcase
  endfunction

  function automatic logic [7:0] bracket_char(input logic [1:0] code,
                                              input logic closing);
    case (code)
      CL_PAREN: return closing ? CH_RPAREN : CH_LPAREN;
      CL_BRACE: return closing ? CH_RBRACE : CH_LBRACE;
      default:  return closing ? CH_RBRACK : CH_LBRACK;
    endcase
  endfunction

  // Drive one beat at the falling edge, with random hold-off cycles in front,
  // and return at the falling edge after the beat is taken.
  task automatic send_byte(input logic [7:0] ch, input logic last);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Send the assembled text, marking its final byte as end of text.
  task automatic send_text();
    foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
  endtask

  // Assemble a run of mostly well-formed C-like text: balanced brackets with
  // some wrong closers, strings (some left open across a newline), both kinds
  // of comment, lone slashes, deep nesting that overruns the stack, and raw
  // noise bytes.
  task automatic compose_text(input int tokens);
    logic [1:0] open_q[$];
    logic [1:0] code;
    int         pick;
    int         n;
    text_q.delete();
    for (int t = 0; t < tokens; t++) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        code = 2'($urandom_range(CL_PAREN, CL_BRACKET));
        open_q.push_back(code);
        text_q.push_back(bracket_char(code, 1'b0));
      end else if (pick < 45) begin
        // Close the innermost bracket most of the time; pop either way.
        code = 2'($urandom_range(CL_PAREN, CL_BRACKET));
        if (open_q.size() > 0) begin
          if ($urandom_range(99) < 85) code = open_q[$];
          void'(open_q.pop_back());
        end
        text_q.push_back(bracket_char(code, 1'b1));
      end else if (pick < 55) begin
        text_q.push_back(CH_NEWLINE);
      end else if (pick < 63) begin
        text_q.push_back(CH_DQUOTE);
        n = $urandom_range(0, 4);
        repeat (n) text_q.push_back(body_char($urandom_range(0, 9)));
        text_q.push_back(($urandom_range(3) == 0) ? CH_NEWLINE : CH_DQUOTE);
      end else if (pick < 69) begin
        text_q.push_back(CH_SLASH);
        text_q.push_back(CH_SLASH);
        n = $urandom_range(0, 5);
        repeat (n) text_q.push_back(body_char($urandom_range(11)));
        text_q.push_back(CH_NEWLINE);
      end else if (pick < 75) begin
        text_q.push_back(CH_SLASH);
        text_q.push_back(CH_STAR);
        n = $urandom_range(0, 6);
        repeat (n) text_q.push_back(body_char($urandom_range(11)));
        text_q.push_back(CH_STAR);
        text_q.push_back(CH_SLASH);
      end else if (pick < 80) begin
        text_q.push_back(CH_SLASH);
        text_q.push_back(8'($urandom_range(255)));
      end else if (pick < 84) begin
        n = $urandom_range(12, 20);
        repeat (n) begin
          code = 2'($urandom_range(CL_PAREN, CL_BRACKET));
          open_q.push_back(code);
          text_q.push_back(bracket_char(code, 1'b0));
        end
      end else begin
        text_q.push_back(8'($urandom_range(255)));
      end
    end
    // Cut some runs short so end of text lands inside strings and comments.
    if ($urandom_range(3) == 0 && text_q.size() > 1) begin
      n = $urandom_range(1, text_q.size() - 1);
      repeat (n) void'(text_q.pop_back());
    end
  endtask

  task automatic random_texts(input int until_count);
    while (bytes_sent < until_count) begin
      compose_text($urandom_range(2, 16));
      send_text();
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed run: closers on an empty stack, a mismatched closer, a string
    // broken by a newline, a line comment hiding a bracket, a block comment
    // that does not close on the slash of its own opener, a pending slash
    // followed by code, the byte extremes, and end of text on a closer.
    text_q = '{CH_RPAREN, CH_RBRACE, CH_RBRACK, CH_LPAREN, CH_RBRACK,
               CH_LBRACE, CH_DQUOTE, 8'h78, CH_NEWLINE,
               CH_SLASH, CH_SLASH, CH_LPAREN, CH_NEWLINE,
               CH_SLASH, CH_STAR, CH_SLASH, CH_LPAREN, CH_STAR, CH_STAR,
               CH_SLASH, CH_SLASH, CH_RPAREN, 8'h00, 8'hFF, CH_RBRACE};
    send_text();

    // Phase one: source idles a third of the time, sink stalls mostly.
    random_texts(220);

    // Phase two: swap the idle rates.
    send_idle = 61;
    recv_idle = 33;
    random_texts(420);

    // Phase three: full rate on both sides.
    send_idle = 0;
    recv_idle = 0;
    random_texts(620);

    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;

    // Drain: wait for every predicted error beat, then give the pipeline
    // time to show any stray beat.
    while (errors_waiting != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
